// File: hw/rtl/hepm_pkg.sv
package hepm_pkg;

    localparam logic [1:0] OP_OLD_HALF     = 2'd0;
    localparam logic [1:0] OP_NEW_HALF     = 2'd1;
    localparam logic [1:0] OP_FLUSH_EXPIRED = 2'd2;
    localparam logic [1:0] OP_FLUSH_ALL    = 2'd3;

    localparam logic [1:0] KIND_RENAMED  = 2'd0;
    localparam logic [1:0] KIND_REMOVED  = 2'd1;
    localparam logic [1:0] KIND_CREATED  = 2'd2;
    localparam logic [1:0] KIND_OVERFLOW = 2'd3;

    typedef struct packed {
        logic start;
        logic restart;
        logic scan_step;
        logic append;
        logic emit;
    } hepm_cmd_t;

    typedef struct packed {
        logic cur_valid;
        logic hit;
        logic own_full;
        logic found;
        logic scan_end;
        logic out_free;
    } hepm_status_t;

endpackage

// File: hw/rtl/hepm_ctrl.sv
module hepm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic [1:0]            s_operation,
    output logic                  s_ready,
    input  hepm_pkg::hepm_status_t status,
    output hepm_pkg::hepm_cmd_t   cmd
);
    import hepm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH_SCAN,
        ST_MATCH_OUT,
        ST_FLUSH_SCAN,
        ST_FLUSH_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = s_operation[1] ? ST_FLUSH_SCAN : ST_MATCH_SCAN;
                end
            end
            ST_MATCH_SCAN: begin
                if (!status.cur_valid) begin
                    if (status.own_full) begin
                        state_next = ST_MATCH_OUT;
                    end else begin
                        cmd.append = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd.scan_step = 1'b1;
                    if (status.hit) begin
                        state_next = ST_MATCH_OUT;
                    end
                end
            end
            ST_MATCH_OUT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.scan_end) begin
                    state_next = status.found ? ST_FLUSH_OUT : ST_IDLE;
                end
            end
            ST_FLUSH_OUT: begin
                if (status.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.restart = 1'b1;
                    state_next  = ST_FLUSH_SCAN;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/hepm_datapath.sv
module hepm_datapath #(
    parameter int LIST_DEPTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [31:0]            cfg_wdata,
    input  logic [1:0]             s_operation,
    input  logic [15:0]            s_tag,
    input  logic [31:0]            s_stamp,
    input  hepm_pkg::hepm_cmd_t    cmd,
    output hepm_pkg::hepm_status_t status,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_kind,
    output logic [15:0]            m_path_tag,
    output logic [15:0]            m_former_tag,
    output logic [31:0]            m_event_time,
    output logic                   m_last
);
    import hepm_pkg::*;

    localparam int IW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int QW = $clog2(2 * LIST_DEPTH + 1);

    logic [15:0]   tag_mem  [2][LIST_DEPTH];
    logic [31:0]   time_mem [2][LIST_DEPTH];
    logic [CW-1:0] count_reg [2];

    logic [31:0]   window_reg;
    logic [1:0]    op_reg;
    logic [15:0]   tag_reg;
    logic [31:0]   stamp_reg;
    logic [CW-1:0] idx_reg;
    logic          side_reg;
    logic          found_reg;
    logic          best_side_reg;
    logic [IW-1:0] best_idx_reg;
    logic [15:0]   best_tag_reg;
    logic [31:0]   best_time_reg;
    logic [QW-1:0] qual_cnt_reg;

    logic          m_valid_reg;
    logic [1:0]    m_kind_reg;
    logic [15:0]   m_path_tag_reg;
    logic [15:0]   m_former_tag_reg;
    logic [31:0]   m_event_time_reg;
    logic          m_last_reg;

    logic          scan_side;
    logic          own_side;
    logic          cur_valid;
    logic [15:0]   cur_tag;
    logic [31:0]   cur_time;
    logic [31:0]   diff;
    logic          hit;
    logic          better;
    logic          out_free;

    assign scan_side = op_reg[1] ? side_reg : ~op_reg[0];
    assign own_side  = op_reg[0];
    assign cur_valid = idx_reg < count_reg[scan_side];
    assign cur_tag   = tag_mem[scan_side][idx_reg[IW-1:0]];
    assign cur_time  = time_mem[scan_side][idx_reg[IW-1:0]];
    assign diff      = (cur_time > stamp_reg) ? (cur_time - stamp_reg) : (stamp_reg - cur_time);
    assign out_free  = !m_valid_reg || m_ready;
    assign better    = !found_reg || (cur_time < best_time_reg);

    always_comb begin
        unique case (op_reg)
            OP_OLD_HALF, OP_NEW_HALF: hit = (diff <= window_reg);
            OP_FLUSH_EXPIRED: begin
                hit = (stamp_reg >= cur_time) && ((stamp_reg - cur_time) > window_reg);
            end
            OP_FLUSH_ALL: hit = 1'b1;
            default:      hit = 1'b0;
        endcase
    end

    assign status.cur_valid = cur_valid;
    assign status.hit       = hit;
    assign status.own_full  = (count_reg[own_side] == CW'(LIST_DEPTH));
    assign status.found     = found_reg;
    assign status.scan_end  = !cur_valid && side_reg;
    assign status.out_free  = out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg   <= '0;
            count_reg[0] <= '0;
            count_reg[1] <= '0;
            found_reg    <= 1'b0;
            idx_reg      <= '0;
            side_reg     <= 1'b0;
            qual_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                window_reg <= cfg_wdata;
            end
            if (cmd.start) begin
                op_reg    <= s_operation;
                tag_reg   <= s_tag;
                stamp_reg <= s_stamp;
            end
            if (cmd.start || cmd.restart) begin
                idx_reg      <= '0;
                side_reg     <= 1'b0;
                found_reg    <= 1'b0;
                qual_cnt_reg <= '0;
            end else if (cmd.scan_step) begin
                if (cur_valid) begin
                    idx_reg <= idx_reg + CW'(1);
                    if (hit) begin
                        qual_cnt_reg <= qual_cnt_reg + QW'(1);
                        if (better) begin
                            found_reg     <= 1'b1;
                            best_side_reg <= scan_side;
                            best_idx_reg  <= idx_reg[IW-1:0];
                            best_tag_reg  <= cur_tag;
                            best_time_reg <= cur_time;
                        end
                    end
                end else begin
                    side_reg <= 1'b1;
                    idx_reg  <= '0;
                end
            end

            if (cmd.append) begin
                tag_mem[own_side][count_reg[own_side][IW-1:0]]  <= tag_reg;
                time_mem[own_side][count_reg[own_side][IW-1:0]] <= stamp_reg;
                count_reg[own_side] <= count_reg[own_side] + CW'(1);
            end

            // The matched or selected entry leaves its list; later entries close the gap.
            if (cmd.emit && found_reg) begin
                for (int j = 0; j < LIST_DEPTH - 1; j++) begin
                    if (IW'(j) >= best_idx_reg) begin
                        tag_mem[best_side_reg][j]  <= tag_mem[best_side_reg][j + 1];
                        time_mem[best_side_reg][j] <= time_mem[best_side_reg][j + 1];
                    end
                end
                count_reg[best_side_reg] <= count_reg[best_side_reg] - CW'(1);
            end

            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            if (op_reg[1]) begin
                m_kind_reg       <= best_side_reg ? KIND_CREATED : KIND_REMOVED;
                m_path_tag_reg   <= best_tag_reg;
                m_former_tag_reg <= '0;
                m_event_time_reg <= best_time_reg;
                m_last_reg       <= (qual_cnt_reg == QW'(1));
            end else if (found_reg) begin
                m_kind_reg       <= KIND_RENAMED;
                m_path_tag_reg   <= op_reg[0] ? tag_reg : best_tag_reg;
                m_former_tag_reg <= op_reg[0] ? best_tag_reg : tag_reg;
                m_event_time_reg <= (best_time_reg > stamp_reg) ? best_time_reg : stamp_reg;
                m_last_reg       <= 1'b1;
            end else begin
                m_kind_reg       <= KIND_OVERFLOW;
                m_path_tag_reg   <= tag_reg;
                m_former_tag_reg <= '0;
                m_event_time_reg <= stamp_reg;
                m_last_reg       <= 1'b1;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_path_tag   = m_path_tag_reg;
    assign m_former_tag = m_former_tag_reg;
    assign m_event_time = m_event_time_reg;
    assign m_last       = m_last_reg;

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> out_free)
        else $error("result loaded while the output register is still occupied");

    a_append_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.append |-> (count_reg[own_side] < CW'(LIST_DEPTH)))
        else $error("append into a full list");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg[0] <= CW'(LIST_DEPTH)) && (count_reg[1] <= CW'(LIST_DEPTH)))
        else $error("list count exceeds depth");

    a_flush_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && op_reg[1]) |-> found_reg)
        else $error("flush result emitted without a selected entry");

endmodule

// File: hw/rtl/half_event_pair_matcher.sv
// Pairs the old and new halves of file rename events.
// Input channel (s_valid/s_ready): one transaction carries an operation, a tag and a
// stamp. Old and new halves search the opposite pending list, oldest entry first,
// and either pair (one renamed result), join their own list (no result) or are
// dropped when that list is full (one overflow result). Flushes report every
// removed entry as a removed or created result in ascending time order.
// Output channel (m_valid/m_ready): one transaction per result; m_last marks the
// final result of an input. cfg_we/cfg_wdata write the pairing window.
// A half scans the opposite list entry by entry and stops at its first match or at the
// end of that list. A flush runs one selection scan over both lists per result, and a
// final scan over what is left ends the flush.
// Only one input is processed at a time; s_ready is high while the block is idle.
// A result sits in the output register while the next input is taken; if the
// receiver stalls with a result pending, the block waits before loading another.
// Reset empties both lists, clears the window to zero and drops any held result.
module half_event_pair_matcher #(
    parameter int LIST_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [15:0] s_tag,
    input  logic [31:0] s_stamp,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [15:0] m_path_tag,
    output logic [15:0] m_former_tag,
    output logic [31:0] m_event_time,
    output logic        m_last
);
    import hepm_pkg::*;

    hepm_cmd_t    cmd;
    hepm_status_t status;

    hepm_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_operation),
        .s_ready     (s_ready),
        .status      (status),
        .cmd         (cmd)
    );

    hepm_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_operation  (s_operation),
        .s_tag        (s_tag),
        .s_stamp      (s_stamp),
        .cmd          (cmd),
        .status       (status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_path_tag   (m_path_tag),
        .m_former_tag (m_former_tag),
        .m_event_time (m_event_time),
        .m_last       (m_last)
    );

endmodule
